// ===== hdl/rcxf_pkg.sv =====
// ----------------------------------------------------------------------------
// rcxf_pkg
// Shared types and constants of the raised-cosine crossfader.
// ----------------------------------------------------------------------------
`default_nettype none

package rcxf_pkg;

	localparam logic [23:0] POS_MAX     = 24'hFF_FFFF;
	localparam logic [16:0] FACTOR_ONE  = 17'd65536;
	localparam logic [23:0] LEN_RESET   = 24'd1024;
	localparam logic [3:0]  CHCNT_RESET = 4'd2;

	// ramp table generation, Q30 fixed point
	localparam logic [63:0] PI_Q30  = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam logic [63:0] TAYLOR_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
		64'd90, 64'd132, 64'd182};

	localparam int QUEUE_DEPTH = 4;

	// register select, paddr[2]
	localparam logic REG_LEN   = 1'b0;
	localparam logic REG_CHCNT = 1'b1;

	typedef struct packed {
		logic [23:0] len;
		logic [3:0]  chcnt;
	} cfg_t;

	typedef struct packed {
		logic        first;
		logic        need_div;
		logic        block_last;
		logic        done;
		logic [23:0] pos_eff;
		logic [23:0] pos_after;
	} item_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== hdl/rcxf_front.sv =====
// ----------------------------------------------------------------------------
// rcxf_front
// Accepts input transfers, tracks channel index and fade position, and tags
// each sample for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcxf_front import rcxf_pkg::*; #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  queue_status_t q_status,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic          s_tuser,   // restart
	input  logic          s_tlast,   // block_last
	output logic          push,
	output item_ctrl_t    push_ctrl
);

	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam logic [4:0] MAX_CH = 5'(MAX_CHANNELS);

	logic [23:0]   pos_q;
	logic [CW-1:0] ch_q;

	logic [23:0]   pos_eff;
	logic [CW-1:0] ch_eff;
	logic [4:0]    eff_ch;
	logic          frame_end;
	logic [23:0]   pos_next;
	logic [CW-1:0] ch_next;

	assign s_tready = !q_status.full;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		// restart opens a new frame at position zero
		pos_eff = s_tuser ? '0 : pos_q;
		ch_eff  = s_tuser ? '0 : ch_q;

		if (cfg.chcnt == 4'd0) begin
			eff_ch = 5'd1;
		end else if ({1'b0, cfg.chcnt} > MAX_CH) begin
			eff_ch = MAX_CH;
		end else begin
			eff_ch = {1'b0, cfg.chcnt};
		end

		frame_end = (5'(ch_eff) + 5'd1) >= eff_ch;
		pos_next  = (frame_end && pos_eff != POS_MAX) ? pos_eff + 24'd1 : pos_eff;
		ch_next   = frame_end ? '0 : ch_eff + CW'(1);

		push_ctrl.first      = (ch_eff == '0);
		push_ctrl.need_div   = (ch_eff == '0) && (pos_eff < cfg.len);
		push_ctrl.block_last = s_tlast;
		push_ctrl.done       = pos_next >= cfg.len;
		push_ctrl.pos_eff    = pos_eff;
		push_ctrl.pos_after  = pos_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ch_q  <= '0;
		end else if (push) begin
			pos_q <= pos_next;
			ch_q  <= ch_next;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rcxf_queue.sv =====
// ----------------------------------------------------------------------------
// rcxf_queue
// Small register FIFO between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rcxf_queue import rcxf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output queue_status_t    status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign status.full  = (count_q == NW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/rcxf_back.sv =====
// ----------------------------------------------------------------------------
// rcxf_back
// Per-frame table index division, ramp ROM lookup, and the mix multiply with
// rounding and clamping. Holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rcxf_back import rcxf_pkg::*; #(
	parameter int SAMPLE_BITS     = 24,
	parameter int RAMP_TABLE_SIZE = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [23:0]            cfg_len,
	input  queue_status_t          q_status,
	output logic                   pop,
	input  item_ctrl_t             head_ctrl,
	input  logic [SAMPLE_BITS-1:0] head_old,
	input  logic [SAMPLE_BITS-1:0] head_new,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_mixed,
	output item_ctrl_t             out_ctrl
);

	localparam int SB    = SAMPLE_BITS;
	localparam int QW    = $clog2(RAMP_TABLE_SIZE);
	localparam int DW    = 24 + QW;
	localparam int CNTW  = $clog2(QW);
	localparam int AW    = SB + 19;
	localparam int MW    = AW - 16;
	localparam logic [63:0] TABLE_SIZE64 = 64'(RAMP_TABLE_SIZE);
	localparam logic signed [MW-1:0] SMAX = MW'({(SB - 1){1'b1}});
	localparam logic signed [MW-1:0] SMIN = ~SMAX;

	// entry i = 0.5*(1-cos(pi*i/size)) in Q1.16; upper half mirrored
	function automatic logic [16:0] ramp_entry(input logic [31:0] i);
		logic               mirror;
		logic [63:0]        j;
		logic [63:0]        theta;
		logic [63:0]        t2;
		logic [63:0]        term;
		logic signed [65:0] sum;
		logic [63:0]        c;
		logic [63:0]        f;
		int                 k;
		mirror = (64'(i) << 1) > TABLE_SIZE64;
		j      = mirror ? TABLE_SIZE64 - 64'(i) : 64'(i);
		theta  = (PI_Q30 * j) / TABLE_SIZE64;
		t2     = (theta * theta) >> 30;
		term   = ONE_Q30;
		sum    = $signed({2'b00, ONE_Q30});
		for (k = 1; k <= 7; k++) begin
			term = ((term * t2) >> 30) / TAYLOR_DIV[k - 1];
			if (k % 2 == 1) begin
				sum = sum - $signed({2'b00, term});
			end else begin
				sum = sum + $signed({2'b00, term});
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > $signed({2'b00, ONE_Q30})) begin
			sum = $signed({2'b00, ONE_Q30});
		end
		c = sum[63:0];
		f = (ONE_Q30 - c + 64'd16384) >> 15;
		return mirror ? FACTOR_ONE - f[16:0] : f[16:0];
	endfunction

	logic [16:0] rom [RAMP_TABLE_SIZE];

	for (genvar g = 0; g < RAMP_TABLE_SIZE; g++) begin : g_rom
		assign rom[g] = ramp_entry(32'(g));
	end

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROM,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t                   state_q;
	logic signed [SB-1:0]     old_q;
	logic signed [SB-1:0]     new_q;
	item_ctrl_t               ctrl_q;
	logic [16:0]              factor_q;
	logic [23:0]              rem_q;
	logic [QW-1:0]            dq_q;
	logic [CNTW-1:0]          cnt_q;
	logic signed [AW-1:0]     prod_q;
	logic                     out_valid_q;
	logic [SB-1:0]            out_mixed_q;
	item_ctrl_t               out_ctrl_q;

	logic [DW-1:0]            dividend;
	logic [24:0]              r2;
	logic                     ge;
	logic [24:0]              rdiff;
	logic signed [SB:0]       diff;
	logic signed [AW-1:0]     mix_sum;
	logic signed [MW-1:0]     mix_sh;
	logic [SB-1:0]            mixed;

	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign out_valid = out_valid_q;
	assign out_mixed = out_mixed_q;
	assign out_ctrl  = out_ctrl_q;

	always_comb begin
		dividend = DW'(head_ctrl.pos_eff) * DW'(RAMP_TABLE_SIZE);
		// restoring divide, one quotient bit per cycle; quotient < table size
		r2       = {rem_q, dq_q[QW-1]};
		ge       = r2 >= {1'b0, cfg_len};
		rdiff    = r2 - {1'b0, cfg_len};
		// old*(1-f) + new*f == old + (new-old)*f
		diff     = {new_q[SB-1], new_q} - {old_q[SB-1], old_q};
		mix_sum  = (AW'(old_q) <<< 16) + prod_q + AW'(32'sd32768);
		mix_sh   = $signed(mix_sum[AW-1:16]);
		if (mix_sh > SMAX) begin
			mixed = SMAX[SB-1:0];
		end else if (mix_sh < SMIN) begin
			mixed = SMIN[SB-1:0];
		end else begin
			mixed = mix_sh[SB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			old_q       <= '0;
			new_q       <= '0;
			ctrl_q      <= '0;
			factor_q    <= '0;
			rem_q       <= '0;
			dq_q        <= '0;
			cnt_q       <= '0;
			prod_q      <= '0;
			out_valid_q <= 1'b0;
			out_mixed_q <= '0;
			out_ctrl_q  <= '0;
		end else begin
			// in ST_OUT the output register is either held or reloaded below
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						old_q  <= head_old;
						new_q  <= head_new;
						ctrl_q <= head_ctrl;
						if (head_ctrl.first && head_ctrl.need_div) begin
							rem_q   <= dividend[DW-1:QW];
							dq_q    <= dividend[QW-1:0];
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end else begin
							if (head_ctrl.first) begin
								factor_q <= FACTOR_ONE;
							end
							state_q <= ST_MUL;
						end
					end
				end
				ST_DIV: begin
					rem_q <= ge ? rdiff[23:0] : r2[23:0];
					dq_q  <= {dq_q[QW-2:0], ge};
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(QW - 1)) begin
						state_q <= ST_ROM;
					end
				end
				ST_ROM: begin
					factor_q <= rom[dq_q];
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					prod_q  <= AW'(diff) * AW'($signed({1'b0, factor_q}));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_mixed_q <= mixed;
						out_ctrl_q  <= ctrl_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/raised_cosine_crossfader.sv =====
// ----------------------------------------------------------------------------
// raised_cosine_crossfader
// Raised-cosine crossfade of two interleaved sample streams, APB registers.
// ----------------------------------------------------------------------------
// Each input transfer carries one channel sample of the old and the new chain;
// the output is old*(1-f)+new*f rounded to the sample width, with f taken once
// per frame from a raised-cosine table at index pos*RAMP_TABLE_SIZE/length
// (f = 1.0 once the position reaches the length). In the back end a sample is
// dequeued, multiplied, then rounded and registered. The first sample of a
// frame that is still fading first takes its table index from a bit-serial
// restoring divider, one quotient bit a cycle (10 bits at 1024 entries),
// followed by the registered table read.
// A 4-entry queue sits between input classification and the back end, and the
// output register lets the back end finish the next sample while a result
// waits. Registers: 0x0 transition_length (24 bits), 0x4 channel_count.
// ----------------------------------------------------------------------------
`default_nettype none

module raised_cosine_crossfader import rcxf_pkg::*; #(
	parameter int MAX_CHANNELS    = 8,
	parameter int RAMP_TABLE_SIZE = 1024,
	parameter int SAMPLE_BITS     = 24
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// s_tdata: old_sample, new_sample
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	input  logic                                     s_tuser,  // restart
	input  logic                                     s_tlast,  // block_last
	// m_tdata: mixed_sample, fade_position
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	output logic [((SAMPLE_BITS + 24 + 7) / 8) * 8 - 1:0] m_tdata,
	output logic                                     m_tuser,  // fade_done
	output logic                                     m_tlast,  // block_end
	input  logic                                     psel,
	input  logic                                     penable,
	input  logic                                     pwrite,
	input  logic [2:0]                               paddr,
	input  logic [31:0]                              pwdata,
	output logic [31:0]                              prdata,
	output logic                                     pready
);

	localparam int SB  = SAMPLE_BITS;
	localparam int ODW = ((SAMPLE_BITS + 24 + 7) / 8) * 8;
	localparam int QDW = $bits(item_ctrl_t) + 2 * SB;

	cfg_t          cfg_q;
	queue_status_t q_status;
	logic          push;
	item_ctrl_t    push_ctrl;
	logic          pop;
	logic [QDW-1:0] pop_data;
	item_ctrl_t    head_ctrl;
	logic          out_valid;
	logic [SB-1:0] out_mixed;
	item_ctrl_t    out_ctrl;
	logic          cfg_wr;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.len   <= LEN_RESET;
			cfg_q.chcnt <= CHCNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LEN:   cfg_q.len   <= pwdata[23:0];
				REG_CHCNT: cfg_q.chcnt <= pwdata[3:0];
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_LEN:   prdata = 32'(cfg_q.len);
			REG_CHCNT: prdata = 32'(cfg_q.chcnt);
			default:   prdata = '0;
		endcase
	end

	rcxf_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_status (q_status),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.push     (push),
		.push_ctrl(push_ctrl)
	);

	rcxf_queue #(
		.WIDTH(QDW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctrl, s_tdata[2*SB-1:0]}),
		.pop      (pop),
		.pop_data (pop_data),
		.status   (q_status)
	);

	assign head_ctrl = pop_data[QDW-1:2*SB];

	rcxf_back #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.RAMP_TABLE_SIZE(RAMP_TABLE_SIZE)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_len  (cfg_q.len),
		.q_status (q_status),
		.pop      (pop),
		.head_ctrl(head_ctrl),
		.head_old (pop_data[SB-1:0]),
		.head_new (pop_data[2*SB-1:SB]),
		.out_valid(out_valid),
		.out_ready(m_tready),
		.out_mixed(out_mixed),
		.out_ctrl (out_ctrl)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = ODW'({out_ctrl.pos_after, out_mixed});
	assign m_tuser  = out_ctrl.done;
	assign m_tlast  = out_ctrl.block_last;

	// fade_done must agree with the reported position
	a_done_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == (out_ctrl.pos_after >= cfg_q.len)))
		else $error("fade_done disagrees with fade_position");

	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue full and empty at once");

	// a dequeue never happens from an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("dequeue from empty queue");

	a_done_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser && cfg_q.len != 24'd0) |-> (out_ctrl.pos_after != 24'd0))
		else $error("fade done at position zero with nonzero length");

endmodule

`default_nettype wire
